// File: rtl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg : shared types, codes and tables
// Types, register codes and the fixed unscrambling patterns used by the
// scrambled MMC3 bank mapper front end.
// ----------------------------------------------------------------------------
package smm_pkg;

    typedef enum logic [1:0] {
        CMD_CPU_WRITE  = 2'd0,
        CMD_PRG_LOOKUP = 2'd1,
        CMD_CHR_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_MMC3    = 3'd1,
        ACT_MIRROR  = 3'd2,
        ACT_REFRESH = 3'd3,
        ACT_LOOKUP  = 3'd4
    } action_t;

    // Offsets within the $5xxx register window.
    localparam logic [2:0] SEL_MODE     = 3'd0;
    localparam logic [2:0] SEL_OUTER    = 3'd1;
    localparam logic [2:0] SEL_SCRAMBLE = 3'd7;

    // MMC3 register codes of interest after unscrambling.
    localparam logic [2:0] MMC3_REG_BANK_SELECT = 3'd0;
    localparam logic [2:0] MMC3_REG_MIRROR      = 3'd2;

    // Configuration register indexes.
    localparam logic REG_WIDE_VARIANT = 1'b0;
    localparam logic REG_FOUR_SCREEN  = 1'b1;

    localparam int PADDR_W = 3;

    localparam logic [2:0] ADDR_PERM [8][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd3, 3'd2, 3'd0, 3'd4, 3'd1, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd5, 3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd6, 3'd4},
        '{3'd3, 3'd1, 3'd0, 3'd4, 3'd2, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7}
    };

    localparam logic [2:0] DATA_PERM [8][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd2, 3'd6, 3'd1, 3'd7, 3'd3, 3'd4, 3'd5},
        '{3'd0, 3'd5, 3'd4, 3'd1, 3'd7, 3'd2, 3'd6, 3'd3},
        '{3'd0, 3'd6, 3'd3, 3'd7, 3'd5, 3'd2, 3'd4, 3'd1},
        '{3'd0, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1, 3'd7, 3'd4},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7}
    };

    // Mapper state seen by both the bus decoder and the lookup logic.
    typedef struct packed {
        logic [7:0] mode;
        logic [7:0] outer;
        logic [2:0] scramble;
        logic       wide_variant;
        logic       four_screen;
    } map_state_t;

    // State updates requested by a bus write.
    typedef struct packed {
        logic       mode_we;
        logic       outer_we;
        logic       scramble_we;
        logic [7:0] wdata;
    } state_upd_t;

    typedef struct packed {
        action_t     action;
        logic [2:0]  mmc3_register;
        logic [7:0]  mmc3_data;
        logic        mirror_horizontal;
        logic [7:0]  prg_page;
        logic [10:0] chr_page;
    } result_t;

    localparam result_t RESULT_NONE = '{
        action: ACT_NONE, mmc3_register: 3'd0, mmc3_data: 8'd0,
        mirror_horizontal: 1'b0, prg_page: 8'd0, chr_page: 11'd0
    };

endpackage

// File: rtl/smm_bus_write.sv
// ----------------------------------------------------------------------------
// smm_bus_write : CPU write decoder
// Decodes $5xxx register writes and unscrambles $8000-$FFFF writes into
// MMC3 register writes or mirroring changes.
// ----------------------------------------------------------------------------
module smm_bus_write
    import smm_pkg::*;
(
    input  map_state_t  state,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output result_t     result,
    output state_upd_t  upd
);

    logic [2:0] perm_index;
    logic [2:0] mmc3_reg;

    assign perm_index = {address[14], address[13], address[0]};
    assign mmc3_reg   = ADDR_PERM[state.scramble][perm_index];

    always_comb begin
        result      = RESULT_NONE;
        upd         = '0;
        upd.wdata   = data;
        if (address[15:12] == 4'h5) begin
            unique case (address[2:0])
                SEL_MODE: begin
                    if (state.mode != data) begin
                        upd.mode_we   = 1'b1;
                        result.action = ACT_REFRESH;
                    end
                end
                SEL_OUTER: begin
                    if (state.outer != data) begin
                        upd.outer_we  = 1'b1;
                        result.action = ACT_REFRESH;
                    end
                end
                SEL_SCRAMBLE: upd.scramble_we = 1'b1;
                default: ;
            endcase
        end else if (address[15]) begin
            if (mmc3_reg == MMC3_REG_MIRROR) begin
                if (!state.four_screen) begin
                    result.action            = ACT_MIRROR;
                    result.mirror_horizontal = data[0];
                end
            end else begin
                result.action        = ACT_MMC3;
                result.mmc3_register = mmc3_reg;
                if (mmc3_reg == MMC3_REG_BANK_SELECT) begin
                    // Bank-select index bits are scrambled; bits 5:3 drop out.
                    result.mmc3_data = {data[7:6], 3'b000,
                                        DATA_PERM[state.scramble][data[2:0]]};
                end else begin
                    result.mmc3_data = data;
                end
            end
        end
    end

endmodule

// File: rtl/smm_bank_lookup.sv
// ----------------------------------------------------------------------------
// smm_bank_lookup : PRG and CHR page translation
// Applies the 128K window, outer bank bits and the NROM-style override to
// an MMC3 bank number.
// ----------------------------------------------------------------------------
module smm_bank_lookup
    import smm_pkg::*;
(
    input  map_state_t  state,
    input  logic [15:0] address,
    input  logic [7:0]  mmc3_bank,
    output logic [7:0]  prg_page,
    output logic [10:0] chr_page
);

    logic [1:0]  slot;
    logic [2:0]  prg_outer;
    logic [3:0]  fixed_low;
    logic [6:0]  fixed_bank;
    logic [4:0]  inner_bank;
    logic [10:0] chr_outer;
    logic [7:0]  chr_bank;

    assign slot = address[14:13];

    // PRG outer bits land at page bits 7:5.
    assign prg_outer = {state.wide_variant & state.outer[3], state.outer[1:0]};

    always_comb begin
        fixed_low  = state.mode[6] ? {state.outer[4], state.mode[2:0]} : state.mode[3:0];
        fixed_bank = {prg_outer, fixed_low};
        inner_bank = state.mode[6] ? {state.outer[4], mmc3_bank[3:0]} : mmc3_bank[4:0];
        if (state.mode[7]) begin
            if (state.mode[5]) begin
                prg_page = {fixed_bank[6:1], slot};
            end else begin
                prg_page = {fixed_bank, slot[0]};
            end
        end else begin
            prg_page = {prg_outer, inner_bank};
        end
    end

    always_comb begin
        chr_outer = state.wide_variant ? {state.outer[3:1], 8'd0}
                                       : {1'b0, state.outer[3:2], 8'd0};
        chr_bank  = state.mode[6] ? {state.outer[5], mmc3_bank[6:0]} : mmc3_bank;
        chr_page  = chr_outer | {3'd0, chr_bank};
    end

endmodule

// File: rtl/scrambled_mmc3_bank_mapper.sv
// ----------------------------------------------------------------------------
// scrambled_mmc3_bank_mapper : scrambled MMC3-clone mapper front end
// Register stage, mapper state, APB configuration and result register
// around the bus-write decoder and the bank lookup logic.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Carries
//   s_*       in         s_valid/s_ready    command, address, data, mmc3_bank
//   m_*       out        m_valid/m_ready    action, register, data, pages
//   APB       in/out     psel/penable       wide_variant, four_screen
//
// Every transaction passes through two register stages: it is captured in
// the input register, then decoded and looked up combinationally into the
// result register, from which its result is offered on m_valid.
// One transaction is taken per cycle unless the result stalls; the decode
// between the two registers sets that rate and updates the mapper state.
// Reset (aresetn, synchronous, active low) empties both stages and loads
// the mapper state with its power-on values.
// A stalled result holds the result register; the input register keeps
// accepting until it is full as well, after which s_ready falls.
module scrambled_mmc3_bank_mapper
    import smm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [15:0]          s_address,
    input  logic [7:0]           s_data,
    input  logic [7:0]           s_mmc3_bank,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_action,
    output logic [2:0]           m_mmc3_register,
    output logic [7:0]           m_mmc3_data,
    output logic                 m_mirror_horizontal,
    output logic [7:0]           m_prg_page,
    output logic [10:0]          m_chr_page,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Input register stage.
    logic        in_valid_reg;
    logic [1:0]  in_command_reg;
    logic [15:0] in_address_reg;
    logic [7:0]  in_data_reg;
    logic [7:0]  in_bank_reg;

    // Mapper state.
    logic [7:0]  mode_reg,   mode_next;
    logic [7:0]  outer_reg,  outer_next;
    logic [2:0]  scramble_reg, scramble_next;
    logic        wide_variant_reg;
    logic        four_screen_reg;

    // Result register stage.
    logic        out_valid_reg;
    result_t     out_reg;

    map_state_t  state;
    result_t     wr_result;
    state_upd_t  wr_upd;
    result_t     result_next;
    logic [7:0]  prg_page;
    logic [10:0] chr_page;
    logic        advance;
    logic        cfg_write;

    // The result register frees up when it is empty or being emptied; the
    // input register moves on into it at that point.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_write = psel && penable && pwrite && pready;

    assign state = '{
        mode: mode_reg, outer: outer_reg, scramble: scramble_reg,
        wide_variant: wide_variant_reg, four_screen: four_screen_reg
    };

    smm_bus_write u_bus_write (
        .state   (state),
        .address (in_address_reg),
        .data    (in_data_reg),
        .result  (wr_result),
        .upd     (wr_upd)
    );

    smm_bank_lookup u_bank_lookup (
        .state     (state),
        .address   (in_address_reg),
        .mmc3_bank (in_bank_reg),
        .prg_page  (prg_page),
        .chr_page  (chr_page)
    );

    // Only a CPU write may change the mode, outer and scramble state, and only
    // when the transaction moves on, so later transactions see it in order.
    always_comb begin
        mode_next     = mode_reg;
        outer_next    = outer_reg;
        scramble_next = scramble_reg;
        result_next   = RESULT_NONE;
        unique case (cmd_t'(in_command_reg))
            CMD_CPU_WRITE: begin
                result_next = wr_result;
                if (advance && wr_upd.mode_we) begin
                    mode_next = wr_upd.wdata;
                end
                if (advance && wr_upd.outer_we) begin
                    outer_next = wr_upd.wdata;
                end
                if (advance && wr_upd.scramble_we) begin
                    scramble_next = wr_upd.wdata[2:0];
                end
            end
            CMD_PRG_LOOKUP: begin
                result_next.action   = ACT_LOOKUP;
                result_next.prg_page = prg_page;
            end
            CMD_CHR_LOOKUP: begin
                result_next.action   = ACT_LOOKUP;
                result_next.chr_page = chr_page;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= 8'h00;
            outer_reg        <= 8'h0F;
            scramble_reg     <= 3'd0;
            wide_variant_reg <= 1'b0;
            four_screen_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            mode_reg     <= mode_next;
            outer_reg    <= outer_next;
            scramble_reg <= scramble_next;
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_WIDE_VARIANT: wide_variant_reg <= pwdata[0];
                    REG_FOUR_SCREEN:  four_screen_reg  <= pwdata[0];
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_address_reg <= s_address;
            in_data_reg    <= s_data;
            in_bank_reg    <= s_mmc3_bank;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    // APB read-back; the port never inserts wait states.
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_WIDE_VARIANT: prdata = {31'd0, wide_variant_reg};
            REG_FOUR_SCREEN:  prdata = {31'd0, four_screen_reg};
        endcase
    end

    assign m_valid             = out_valid_reg;
    assign m_action            = out_reg.action;
    assign m_mmc3_register     = out_reg.mmc3_register;
    assign m_mmc3_data         = out_reg.mmc3_data;
    assign m_mirror_horizontal = out_reg.mirror_horizontal;
    assign m_prg_page          = out_reg.prg_page;
    assign m_chr_page          = out_reg.chr_page;

    // Back-pressure only when both stages hold a transaction.
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled while a stage is empty");

    // Page fields are only filled on lookups.
    a_pages_only_on_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.action != ACT_LOOKUP) |->
            (out_reg.prg_page == 8'd0 && out_reg.chr_page == 11'd0))
        else $error("page field set on a non-lookup result");

    // A mode change that raised a refresh must be visible in the state.
    a_mode_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cmd_t'(in_command_reg) == CMD_CPU_WRITE && wr_upd.mode_we) |=>
            (mode_reg == $past(in_data_reg) && out_reg.action == ACT_REFRESH))
        else $error("mode write did not update state");

    // A stalled result may not be overwritten.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
